@@ sv/mtdw_pkg.sv @@
// ----------------------------------------------------------------------------
// mtdw_pkg: shared types and constants of the multitone DAC word generator
// Field widths, sine ROM geometry, register codes, reset values, the
// pipeline enable bundle and the elaboration-time quarter-wave sine builder.
// ----------------------------------------------------------------------------
package mtdw_pkg;

    // field widths
    localparam int PLEN_W  = 10;
    localparam int STEP_W  = 32;
    localparam int AMP_W   = 7;
    localparam int OFS_W   = 8;
    localparam int IDX_W   = 9;
    localparam int SMP_W   = 8;
    localparam int WORD_W  = 32;
    localparam int WORD_SAMPLES = WORD_W / SMP_W;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - WORD_W - IDX_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD_LENGTH   = 3'd0,
        CFG_PHASE_STEP      = 3'd1,
        CFG_AMP_FUNDAMENTAL = 3'd2,
        CFG_AMP_TENTH       = 3'd3,
        CFG_AMP_FIFTH       = 3'd4,
        CFG_MID_OFFSET      = 3'd5
    } t_cfg_reg;

    // register reset values
    localparam logic [PLEN_W-1:0] RST_PERIOD_LENGTH   = 10'd512;
    localparam logic [STEP_W-1:0] RST_PHASE_STEP      = 32'd8388608;
    localparam logic [AMP_W-1:0]  RST_AMP_FUNDAMENTAL = 7'd50;
    localparam logic [AMP_W-1:0]  RST_AMP_TENTH       = 7'd50;
    localparam logic [AMP_W-1:0]  RST_AMP_FIFTH       = 7'd20;
    localparam logic [OFS_W-1:0]  RST_MID_OFFSET      = 8'd128;

    // index wraps here even when period_length is larger
    localparam int PERIOD_MAX = 512;
    localparam logic [IDX_W:0] PERIOD_MAX_V = (IDX_W + 1)'(PERIOD_MAX);

    localparam int SAMPLES_PER_WORD_DEF = 4;

    // sine ROM geometry (Q1.15 output)
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_N  = SINE_TABLE_DEPTH / 4;
    localparam int QTR_OFS_W  = SINE_AW - 2;
    localparam int QTR_IDX_W  = SINE_AW - 1;
    localparam logic [QTR_IDX_W-1:0] QTR_LAST = QTR_IDX_W'(QUARTER_N);
    localparam int TURN_SCALE = 65536 / SINE_TABLE_DEPTH;
    localparam int SIN_MAG_W  = 15;
    localparam int SIN_W      = SIN_MAG_W + 1;

    // tone set: fundamental, tenth harmonic, fifth harmonic
    localparam int TONES     = 3;
    localparam int TONE_FUND = 0;
    localparam int TONE_TEN  = 1;
    localparam int TONE_FIVE = 2;

    // sample arithmetic
    localparam int FRAC_W = 15;
    localparam int PROD_W = AMP_W + 1 + SIN_W;
    localparam int SUM_W  = 26;
    localparam logic [SMP_W-1:0] MUTE_SAMPLE = 8'h80;
    localparam logic [SMP_W-1:0] SAMPLE_MAX  = 8'hFF;

    // quarter-wave polynomial coefficients (Q15)
    localparam longint unsigned SIN_A = 64'd51472;
    localparam longint unsigned SIN_B = 64'd21167;
    localparam longint unsigned SIN_C = 64'd2463;
    localparam longint unsigned SIN_PEAK = 64'd32767;

    // per-stage load strobes of the datapath pipeline
    typedef struct packed {
        logic s1;   // phase registers
        logic s2;   // sine registers
        logic s3;   // product registers
        logic s4;   // output register
    } t_pipe_en;

    // magnitude of sine at position pos of the first quarter, evaluated
    // at elaboration to fill the constant quarter table
    function automatic logic [SIN_MAG_W-1:0] sine_quarter(input int unsigned pos);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned s;
        z  = pos;
        z  = z * TURN_SCALE * 2;
        z2 = (z * z) >> 15;
        t  = SIN_B - ((SIN_C * z2) >> 15);
        t2 = SIN_A - ((t * z2) >> 15);
        s  = (t2 * z) >> 15;
        if (s > SIN_PEAK) begin
            s = SIN_PEAK;
        end
        return SIN_MAG_W'(s);
    endfunction

endpackage

@@ sv/multitone_dac_word_generator_top.sv @@
// ----------------------------------------------------------------------------
// multitone_dac_word_generator_top: packed multitone DAC word generator
// Direct digital synthesis of offset plus fundamental, tenth and fifth
// harmonic, four 8-bit samples per stream word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries requests; tdata bit 0 is mute. Each
//   accepted request yields exactly one master stream (o_m_*) word:
//   tdata[31:0] packed samples (earliest in bits 7..0), tdata[40:32] the
//   sample index of the first sample, upper bits zero.
//   Mute emits 0x80 in every sample byte and holds index and phase.
//   Configuration: write i_cfg_wdata to register i_cfg_addr while i_cfg_we
//   is high; 0 period_length, 1 phase_step, 2..4 amplitudes of
//   fundamental, tenth and fifth harmonic, 5 mid_offset. Other indexes
//   are dropped. Write only while no request is in flight.
// Timing:
//   One request per clock sustained while the receiver keeps i_m_tready
//   high. A request passes these stages, one register each, before
//   o_m_tvalid rises: phase resolve, sine ROM read, amplitude multiply,
//   sum and saturate. All lanes of a word run in parallel;
//   the per-word lane wrap resolution sets the cycle.
//   A stalled receiver holds the output word; empty stages keep accepting
//   until the four-stage pipeline is full, then o_s_tready drops.
//   Synchronous reset clears index, phase, pipeline valids and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module multitone_dac_word_generator_top #(
    parameter int SAMPLES_PER_WORD = mtdw_pkg::SAMPLES_PER_WORD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mtdw_pkg::S_TDATA_W-1:0]      i_s_tdata,   // [0] mute, [7:1] zero
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mtdw_pkg::M_TDATA_W-1:0]      o_m_tdata,   // [31:0] packed_word,
                                                             // [40:32] start_index
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [mtdw_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mtdw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int OUT_LANES = (SAMPLES_PER_WORD < mtdw_pkg::WORD_SAMPLES)
                             ? SAMPLES_PER_WORD : mtdw_pkg::WORD_SAMPLES;

    // configuration registers
    logic [mtdw_pkg::PLEN_W-1:0] r_period_length;
    logic [mtdw_pkg::STEP_W-1:0] r_phase_step;
    logic [mtdw_pkg::AMP_W-1:0]  r_amp [mtdw_pkg::TONES];
    logic [mtdw_pkg::OFS_W-1:0]  r_mid_offset;

    // pipeline control
    logic r_vld_s1;
    logic r_vld_s2;
    logic r_vld_s3;
    logic r_vld_s4;
    logic w_rdy_s1;
    logic w_rdy_s2;
    logic w_rdy_s3;
    logic w_rdy_s4;
    mtdw_pkg::t_pipe_en w_en;

    // side band carried alongside the lanes
    logic [mtdw_pkg::IDX_W-1:0] r_start_s2;
    logic [mtdw_pkg::IDX_W-1:0] r_start_s3;
    logic                       r_mute_s2;
    logic                       r_mute_s3;

    logic [mtdw_pkg::STEP_W-1:0]        w_phase [OUT_LANES];
    logic [mtdw_pkg::IDX_W-1:0]         w_start_s1;
    logic                               w_mute_s1;
    logic signed [mtdw_pkg::PROD_W-1:0] w_prod [OUT_LANES][mtdw_pkg::TONES];
    logic [mtdw_pkg::WORD_W-1:0]        w_word;
    logic [mtdw_pkg::IDX_W-1:0]         w_start_out;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_length              <= mtdw_pkg::RST_PERIOD_LENGTH;
            r_phase_step                 <= mtdw_pkg::RST_PHASE_STEP;
            r_amp[mtdw_pkg::TONE_FUND]   <= mtdw_pkg::RST_AMP_FUNDAMENTAL;
            r_amp[mtdw_pkg::TONE_TEN]    <= mtdw_pkg::RST_AMP_TENTH;
            r_amp[mtdw_pkg::TONE_FIVE]   <= mtdw_pkg::RST_AMP_FIFTH;
            r_mid_offset                 <= mtdw_pkg::RST_MID_OFFSET;
        end else if (i_cfg_we) begin
            unique case (mtdw_pkg::t_cfg_reg'(i_cfg_addr))
                mtdw_pkg::CFG_PERIOD_LENGTH: begin
                    r_period_length <= i_cfg_wdata[mtdw_pkg::PLEN_W-1:0];
                end
                mtdw_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_wdata[mtdw_pkg::STEP_W-1:0];
                end
                mtdw_pkg::CFG_AMP_FUNDAMENTAL: begin
                    r_amp[mtdw_pkg::TONE_FUND] <= i_cfg_wdata[mtdw_pkg::AMP_W-1:0];
                end
                mtdw_pkg::CFG_AMP_TENTH: begin
                    r_amp[mtdw_pkg::TONE_TEN] <= i_cfg_wdata[mtdw_pkg::AMP_W-1:0];
                end
                mtdw_pkg::CFG_AMP_FIFTH: begin
                    r_amp[mtdw_pkg::TONE_FIVE] <= i_cfg_wdata[mtdw_pkg::AMP_W-1:0];
                end
                mtdw_pkg::CFG_MID_OFFSET: begin
                    r_mid_offset <= i_cfg_wdata[mtdw_pkg::OFS_W-1:0];
                end
                default: begin
                    // unknown register: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    // a stage loads when it is empty or its content moves on; bubbles collapse
    assign w_rdy_s4 = !r_vld_s4 || i_m_tready;
    assign w_rdy_s3 = !r_vld_s3 || w_rdy_s4;
    assign w_rdy_s2 = !r_vld_s2 || w_rdy_s3;
    assign w_rdy_s1 = !r_vld_s1 || w_rdy_s2;

    assign w_en.s1 = w_rdy_s1 && i_s_tvalid;
    assign w_en.s2 = w_rdy_s2 && r_vld_s1;
    assign w_en.s3 = w_rdy_s3 && r_vld_s2;
    assign w_en.s4 = w_rdy_s4 && r_vld_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
            r_vld_s3 <= 1'b0;
            r_vld_s4 <= 1'b0;
        end else begin
            if (w_rdy_s1) begin
                r_vld_s1 <= i_s_tvalid;
            end
            if (w_rdy_s2) begin
                r_vld_s2 <= r_vld_s1;
            end
            if (w_rdy_s3) begin
                r_vld_s3 <= r_vld_s2;
            end
            if (w_rdy_s4) begin
                r_vld_s4 <= r_vld_s3;
            end
        end
    end

    // advance index and mute flag with the lane data
    always_ff @(posedge i_clk) begin
        if (w_en.s2) begin
            r_start_s2 <= w_start_s1;
            r_mute_s2  <= w_mute_s1;
        end
        if (w_en.s3) begin
            r_start_s3 <= r_start_s2;
            r_mute_s3  <= r_mute_s2;
        end
    end

    // -------------------------------------------------------------- datapath
    mtdw_phase #(
        .LANES     (SAMPLES_PER_WORD),
        .OUT_LANES (OUT_LANES)
    ) u_phase (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_en.s1),
        .i_mute          (i_s_tdata[0]),
        .i_period_length (r_period_length),
        .i_phase_step    (r_phase_step),
        .o_phase         (w_phase),
        .o_start         (w_start_s1),
        .o_mute          (w_mute_s1)
    );

    // one lane per sample of the word, all in parallel
    for (genvar k = 0; k < OUT_LANES; k++) begin : g_lane
        mtdw_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (w_phase[k]),
            .i_amp   (r_amp),
            .o_prod  (w_prod[k])
        );
    end

    // merge lanes into the output word register
    mtdw_merge #(
        .OUT_LANES (OUT_LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_en         (w_en.s4),
        .i_mute       (r_mute_s3),
        .i_start      (r_start_s3),
        .i_mid_offset (r_mid_offset),
        .i_prod       (w_prod),
        .o_word       (w_word),
        .o_start      (w_start_out)
    );

    // ----------------------------------------------------------------- ports
    assign o_s_tready = w_rdy_s1;
    assign o_m_tvalid = r_vld_s4;
    assign o_m_tdata  = {{mtdw_pkg::M_PAD_W{1'b0}}, w_start_out, w_word};

`ifndef SYNTHESIS
    // a full pipeline behind a stalled receiver must refuse requests
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_s1 && r_vld_s2 && r_vld_s3 && r_vld_s4 && !i_m_tready) |-> !o_s_tready)
        else $error("request accepted into a full pipeline");

    // an empty entry stage always takes a request
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld_s1 |-> o_s_tready)
        else $error("request refused with an empty entry stage");

    // a result under stall is not overwritten by the stage behind it
    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(w_word)))
        else $error("stalled result word changed");
`endif

endmodule

@@ sv/mtdw_phase.sv @@
// ----------------------------------------------------------------------------
// mtdw_phase: sample index and phase accumulator for one word of lanes
// Resolves the index wraps of all lanes of a request combinationally and
// registers the phase of every output lane.
// ----------------------------------------------------------------------------
module mtdw_phase #(
    parameter int LANES     = mtdw_pkg::SAMPLES_PER_WORD_DEF,
    parameter int OUT_LANES = mtdw_pkg::WORD_SAMPLES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic                           i_mute,
    input  logic [mtdw_pkg::PLEN_W-1:0]    i_period_length,
    input  logic [mtdw_pkg::STEP_W-1:0]    i_phase_step,
    output logic [mtdw_pkg::STEP_W-1:0]    o_phase [OUT_LANES],
    output logic [mtdw_pkg::IDX_W-1:0]     o_start,
    output logic                           o_mute
);

    localparam int DIST_W = $clog2(LANES + 1);

    logic [mtdw_pkg::IDX_W-1:0]  r_index;
    logic [mtdw_pkg::STEP_W-1:0] r_accum;
    logic [mtdw_pkg::IDX_W-1:0]  n_index;
    logic [mtdw_pkg::STEP_W-1:0] n_accum;

    logic [mtdw_pkg::STEP_W-1:0] r_phase [OUT_LANES];
    logic [mtdw_pkg::IDX_W-1:0]  r_start;
    logic                        r_mute;

    logic [mtdw_pkg::IDX_W:0]    w_next;
    logic                        w_wrapped;
    logic [DIST_W-1:0]           w_dist;
    logic                        w_lane_wrap [LANES];
    logic [DIST_W-1:0]           w_lane_dist [LANES];
    logic [mtdw_pkg::STEP_W-1:0] w_phase [OUT_LANES];

    // walk the lanes: each lane sees how many steps it is past the base
    // and whether a wrap cleared the accumulator before it
    always_comb begin
        n_index   = r_index;
        w_wrapped = 1'b0;
        w_dist    = '0;
        w_next    = '0;
        for (int k = 0; k < LANES; k++) begin
            w_lane_wrap[k] = w_wrapped;
            w_lane_dist[k] = w_dist;
            w_next = {1'b0, n_index} + 1'b1;
            if ((w_next >= i_period_length) || (w_next >= mtdw_pkg::PERIOD_MAX_V)) begin
                n_index   = '0;
                w_wrapped = 1'b1;
                w_dist    = '0;
            end else begin
                n_index = w_next[mtdw_pkg::IDX_W-1:0];
                w_dist  = w_dist + 1'b1;
            end
        end
        n_accum = (w_wrapped ? '0 : r_accum)
                + i_phase_step * {{(mtdw_pkg::STEP_W - DIST_W){1'b0}}, w_dist};
    end

    for (genvar k = 0; k < OUT_LANES; k++) begin : g_lane_phase
        assign w_phase[k] = (w_lane_wrap[k] ? '0 : r_accum)
                          + i_phase_step
                          * {{(mtdw_pkg::STEP_W - DIST_W){1'b0}}, w_lane_dist[k]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_accum <= '0;
        end else if (i_fire && !i_mute) begin
            r_index <= n_index;
            r_accum <= n_accum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_phase <= w_phase;
            r_start <= r_index;
            r_mute  <= i_mute;
        end
    end

    assign o_phase = r_phase;
    assign o_start = r_start;
    assign o_mute  = r_mute;

`ifndef SYNTHESIS
    // every path to index zero also clears the accumulator
    a_zero_index_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_index == '0) |-> (r_accum == '0))
        else $error("index zero with nonzero phase accumulator");

    a_mute_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_mute) |=> ($stable(r_index) && $stable(r_accum)))
        else $error("muted request moved the generator state");

    a_index_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_mute) |=>
            ((r_index == '0) || ({1'b0, r_index} < $past(i_period_length))))
        else $error("sample index left the period after a step");
`endif

endmodule

@@ sv/mtdw_lane.sv @@
// ----------------------------------------------------------------------------
// mtdw_lane: three-tone sine lookup and amplitude scaling for one sample
// Derives the harmonic phases, reads the quarter-wave ROM and weights each
// tone by its amplitude over two register stages.
// ----------------------------------------------------------------------------
module mtdw_lane (
    input  logic                                i_clk,
    input  mtdw_pkg::t_pipe_en                  i_en,
    input  logic [mtdw_pkg::STEP_W-1:0]         i_phase,
    input  logic [mtdw_pkg::AMP_W-1:0]          i_amp  [mtdw_pkg::TONES],
    output logic signed [mtdw_pkg::PROD_W-1:0]  o_prod [mtdw_pkg::TONES]
);

    logic [mtdw_pkg::SIN_MAG_W-1:0] w_qtab [mtdw_pkg::QUARTER_N + 1];

    logic [mtdw_pkg::STEP_W-1:0]    w_ph   [mtdw_pkg::TONES];
    logic [mtdw_pkg::SINE_AW-1:0]   w_addr [mtdw_pkg::TONES];
    logic [mtdw_pkg::QTR_IDX_W-1:0] w_fold [mtdw_pkg::TONES];
    logic [mtdw_pkg::SIN_MAG_W-1:0] w_mag  [mtdw_pkg::TONES];
    logic signed [mtdw_pkg::SIN_W-1:0] w_sine [mtdw_pkg::TONES];

    logic signed [mtdw_pkg::SIN_W-1:0]  r_sine [mtdw_pkg::TONES];
    logic signed [mtdw_pkg::PROD_W-1:0] r_prod [mtdw_pkg::TONES];

    // constant quarter-wave table, endpoint included
    for (genvar g = 0; g <= mtdw_pkg::QUARTER_N; g++) begin : g_qtab
        assign w_qtab[g] = mtdw_pkg::sine_quarter(g);
    end

    // harmonic phases modulo 2^32 by shift-add
    assign w_ph[mtdw_pkg::TONE_FUND] = i_phase;
    assign w_ph[mtdw_pkg::TONE_TEN]  = (i_phase << 3) + (i_phase << 1);
    assign w_ph[mtdw_pkg::TONE_FIVE] = (i_phase << 2) + i_phase;

    // fold odd quarters back, negate the second half-turn
    always_comb begin
        for (int t = 0; t < mtdw_pkg::TONES; t++) begin
            w_addr[t] = w_ph[t][mtdw_pkg::STEP_W-1 -: mtdw_pkg::SINE_AW];
            if (w_addr[t][mtdw_pkg::SINE_AW-2]) begin
                w_fold[t] = mtdw_pkg::QTR_LAST
                          - {1'b0, w_addr[t][mtdw_pkg::QTR_OFS_W-1:0]};
            end else begin
                w_fold[t] = {1'b0, w_addr[t][mtdw_pkg::QTR_OFS_W-1:0]};
            end
            w_mag[t] = w_qtab[w_fold[t]];
            if (w_addr[t][mtdw_pkg::SINE_AW-1]) begin
                w_sine[t] = -$signed({1'b0, w_mag[t]});
            end else begin
                w_sine[t] = $signed({1'b0, w_mag[t]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sine <= w_sine;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int t = 0; t < mtdw_pkg::TONES; t++) begin
                r_prod[t] <= $signed({1'b0, i_amp[t]}) * r_sine[t];
            end
        end
    end

    assign o_prod = r_prod;

endmodule

@@ sv/mtdw_merge.sv @@
// ----------------------------------------------------------------------------
// mtdw_merge: sample summation, saturation and word packing
// Adds offset and weighted tones per lane, clamps to the DAC code range and
// packs the lanes into the output word register.
// ----------------------------------------------------------------------------
module mtdw_merge #(
    parameter int OUT_LANES = mtdw_pkg::WORD_SAMPLES
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic                               i_mute,
    input  logic [mtdw_pkg::IDX_W-1:0]         i_start,
    input  logic [mtdw_pkg::OFS_W-1:0]         i_mid_offset,
    input  logic signed [mtdw_pkg::PROD_W-1:0] i_prod [OUT_LANES][mtdw_pkg::TONES],
    output logic [mtdw_pkg::WORD_W-1:0]        o_word,
    output logic [mtdw_pkg::IDX_W-1:0]         o_start
);

    localparam int SMP = mtdw_pkg::SMP_W;
    localparam int FW  = mtdw_pkg::FRAC_W;

    logic signed [mtdw_pkg::SUM_W-1:0] w_sum [OUT_LANES];
    logic [mtdw_pkg::WORD_W-1:0]       n_word;
    logic [mtdw_pkg::WORD_W-1:0]       r_word;
    logic [mtdw_pkg::IDX_W-1:0]        r_start;

    always_comb begin
        n_word = '0;
        for (int k = 0; k < OUT_LANES; k++) begin
            w_sum[k] = $signed({{(mtdw_pkg::SUM_W - mtdw_pkg::OFS_W - FW){1'b0}},
                                i_mid_offset, {FW{1'b0}}});
            for (int t = 0; t < mtdw_pkg::TONES; t++) begin
                w_sum[k] = w_sum[k]
                         + {{(mtdw_pkg::SUM_W - mtdw_pkg::PROD_W){i_prod[k][t][mtdw_pkg::PROD_W-1]}},
                            i_prod[k][t]};
            end
            // mute forces the mid code; else drop below zero, clamp above full scale
            if (i_mute) begin
                n_word[k*SMP +: SMP] = mtdw_pkg::MUTE_SAMPLE;
            end else if (w_sum[k][mtdw_pkg::SUM_W-1]) begin
                n_word[k*SMP +: SMP] = '0;
            end else if (|w_sum[k][mtdw_pkg::SUM_W-2:FW+SMP]) begin
                n_word[k*SMP +: SMP] = mtdw_pkg::SAMPLE_MAX;
            end else begin
                n_word[k*SMP +: SMP] = w_sum[k][FW+SMP-1:FW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word  <= n_word;
            r_start <= i_start;
        end
    end

    assign o_word  = r_word;
    assign o_start = r_start;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multitone DAC word generator
// Drives muted and unmuted requests into the slave stream and checks every packed word
// and start index on the master stream against a cycle-free model of the
// three-tone synthesis: a directed table first, then randomized register
// settings and request runs with random idle and stall gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtdw_pkg::*;

    // unmapped register indexes: writes there must leave every register as is
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_7 = 3'd7;

    localparam logic [WORD_W-1:0] MUTE_WORD   = {WORD_SAMPLES{MUTE_SAMPLE}};
    localparam logic [WORD_W-1:0] FULL_WORD   = {WORD_SAMPLES{SAMPLE_MAX}};
    localparam int          RANDOM_ITEMS  = 900;
    localparam int          TAIL_CYCLES   = 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          MAX_GAP       = 17;
    localparam int          PRINT_LIMIT   = 40;

    // one result word as it leaves the block
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  first_idx;
    } dac_word_t;

    typedef enum bit {ROW_REQUEST, ROW_REG_WRITE} row_kind_t;

    // one line of the directed stimulus table
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_ADDR_W-1:0]   addr;
        logic [CFG_DATA_W-1:0]   data;
        logic                    mute;
        bit                      known;   // want holds a hand-typed result
        dac_word_t               want;
    } stim_row_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;   // [0] mute, [7:1] zero
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;          // [31:0] packed_word, [40:32] start_index
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    // register copies of the model, loaded with the reset defaults
    logic [PLEN_W-1:0] cfg_period = RST_PERIOD_LENGTH;
    logic [STEP_W-1:0] cfg_step   = RST_PHASE_STEP;
    logic [AMP_W-1:0]  amp_fund   = RST_AMP_FUNDAMENTAL;
    logic [AMP_W-1:0]  amp_tenth  = RST_AMP_TENTH;
    logic [AMP_W-1:0]  amp_fifth  = RST_AMP_FIFTH;
    logic [OFS_W-1:0]  cfg_offset = RST_MID_OFFSET;

    // synthesis state of the model
    int unsigned       gen_index = 0;
    logic [STEP_W-1:0] gen_phase = '0;

    dac_word_t   pending_words[$];
    stim_row_t   directed[$];
    int unsigned cycle_count = 0;
    int unsigned words_checked = 0;
    int          mismatches = 0;
    int          rx_hold = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;

    multitone_dac_word_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // model of the synthesis
    // ------------------------------------------------------------------------

    // Q1.15 sine at the ROM address taken from the top bits of a phase:
    // quarter-wave odd polynomial, mirrored for odd quarters, negated for
    // the second half turn
    function automatic int sine_q15(input logic [STEP_W-1:0] ph);
        logic [SINE_AW-1:0] addr;
        longint unsigned    pos;
        longint unsigned    z;
        longint unsigned    z2;
        longint unsigned    poly;
        longint unsigned    mag;
        addr = ph[STEP_W-1 -: SINE_AW];
        pos  = addr[SINE_AW-3:0];
        pos  = pos * TURN_SCALE;
        if (addr[SINE_AW-2]) begin
            pos = 16384 - pos;
        end
        z    = pos << 1;
        z2   = (z * z) >> 15;
        poly = SIN_B - ((SIN_C * z2) >> 15);
        poly = SIN_A - ((poly * z2) >> 15);
        mag  = (poly * z) >> 15;
        if (mag > SIN_PEAK) begin
            mag = SIN_PEAK;
        end
        return addr[SINE_AW-1] ? -int'(mag) : int'(mag);
    endfunction

    // one DAC code: offset plus weighted fundamental, tenth and fifth
    // harmonic, truncated and clamped to the code range
    function automatic logic [SMP_W-1:0] dac_sample(input logic [STEP_W-1:0] ph);
        logic [STEP_W-1:0] ph10;
        logic [STEP_W-1:0] ph5;
        longint            acc;
        ph10 = ph * 10;
        ph5  = ph * 5;
        acc  = longint'(cfg_offset) <<< FRAC_W;
        acc += longint'(amp_fund)  * sine_q15(ph);
        acc += longint'(amp_tenth) * sine_q15(ph10);
        acc += longint'(amp_fifth) * sine_q15(ph5);
        if (acc < 0) begin
            return '0;
        end
        acc = acc >>> FRAC_W;
        if (acc > 255) begin
            return SAMPLE_MAX;
        end
        return acc[SMP_W-1:0];
    endfunction

    // next packed word; advance index and phase per generated sample, hold
    // both on mute
    task automatic next_dac_word(input logic mute, output dac_word_t w);
        int unsigned nxt;
        w.first_idx = gen_index[IDX_W-1:0];
        w.word      = '0;
        for (int k = 0; k < WORD_SAMPLES; k++) begin
            if (mute) begin
                w.word[k*SMP_W +: SMP_W] = MUTE_SAMPLE;
            end else begin
                w.word[k*SMP_W +: SMP_W] = dac_sample(gen_phase);
                nxt       = gen_index + 1;
                gen_phase = gen_phase + cfg_step;
                // wrap at the period, and at the index range whatever the period
                if (nxt >= cfg_period || nxt >= PERIOD_MAX) begin
                    nxt       = 0;
                    gen_phase = '0;
                end
                gen_index = nxt;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic stim_row_t req_row(input logic mute);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_REQUEST;
        row.mute = mute;
        return row;
    endfunction

    function automatic stim_row_t req_known(input logic mute, input logic [WORD_W-1:0] word,
                                            input logic [IDX_W-1:0] idx);
        stim_row_t row;
        row                = req_row(mute);
        row.known          = 1'b1;
        row.want.word      = word;
        row.want.first_idx = idx;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_REG_WRITE;
        row.addr = addr;
        row.data = data;
        return row;
    endfunction

    // half the time fill the bits above the register width with junk
    function automatic logic [CFG_DATA_W-1:0] with_stray_bits(input logic [CFG_DATA_W-1:0] v,
                                                             input int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            return v;
        end
        return (w >= CFG_DATA_W) ? v : ((junk << w) | v);
    endfunction

    function automatic logic [AMP_W-1:0] pick_amp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return AMP_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic int tx_gap();
        return tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic int rx_gap();
        return rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // write one register; leave the enable high so back-to-back writes need
    // no second assignment in a step, the next request drops it
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            CFG_PERIOD_LENGTH:   cfg_period = data[PLEN_W-1:0];
            CFG_PHASE_STEP:      cfg_step   = data[STEP_W-1:0];
            CFG_AMP_FUNDAMENTAL: amp_fund   = data[AMP_W-1:0];
            CFG_AMP_TENTH:       amp_tenth  = data[AMP_W-1:0];
            CFG_AMP_FIFTH:       amp_fifth  = data[AMP_W-1:0];
            CFG_MID_OFFSET:      cfg_offset = data[OFS_W-1:0];
            default: ;
        endcase
    endtask

    // hold valid until the request is taken, predict its word, then drop
    // valid for a gap of gap_after when a gap is wanted
    task automatic push_request(input logic mute, input int gap_after, input bit known,
                                input dac_word_t want);
        dac_word_t w;
        i_cfg_we   <= 1'b0;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'(mute);
        do @(posedge i_clk); while (!o_s_tready);
        next_dac_word(mute, w);
        pending_words.push_back(known ? want : w);
        if (gap_after > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap_after) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted word has come back
    task automatic drain_words();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch in %s: got %h, expected %h (word %0d, cycle %0d)",
                     what, got, want, words_checked, cycle_count);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: check each taken word against the oldest prediction,
    // then, when rx_idle is set, hold i_m_tready low for a random gap before taking the next
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : word_check
        dac_word_t want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with no request pending", o_m_tdata[WORD_W-1:0], '0);
            end else begin
                want = pending_words.pop_front();
                if (o_m_tdata[WORD_W-1:0] !== want.word) begin
                    report_mismatch("packed_word", o_m_tdata[WORD_W-1:0], want.word);
                end
                if (o_m_tdata[WORD_W +: IDX_W] !== want.first_idx) begin
                    report_mismatch("start_index", WORD_W'(o_m_tdata[WORD_W +: IDX_W]),
                                    WORD_W'(want.first_idx));
                end
            end
            words_checked <= words_checked + 1;
            rx_hold = rx_gap();
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end
        i_m_tready <= (rx_hold == 0);
    end

    // a hung handshake ends the run here
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                    gap;
        int                    run;
        int                    mute_odds;
        int                    random_sent;
        logic [PLEN_W-1:0]     plen;
        logic [STEP_W-1:0]     step;
        logic [OFS_W-1:0]      ofs;
        logic                  mute;
        bit                    last_of_run;

        // directed table: reset defaults, mute holding the index, code
        // extremes, ignored unmapped writes, short periods, full-scale
        // amplitudes with both clamps, and a period beyond the index range
        directed.push_back(req_known(1'b1, MUTE_WORD, 9'd0));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_known(1'b1, MUTE_WORD, 9'd8));
        directed.push_back(reg_row(CFG_AMP_FUNDAMENTAL, 32'd0));
        directed.push_back(reg_row(CFG_AMP_TENTH, 32'd0));
        directed.push_back(reg_row(CFG_AMP_FIFTH, 32'd0));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd255));
        directed.push_back(req_known(1'b0, FULL_WORD, 9'd8));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd0));
        directed.push_back(req_known(1'b0, '0, 9'd12));
        directed.push_back(req_known(1'b1, MUTE_WORD, 9'd16));
        directed.push_back(reg_row(CFG_UNMAPPED_6, 32'hFFFF_FFFF));
        directed.push_back(reg_row(CFG_UNMAPPED_7, 32'h1234_5678));
        directed.push_back(req_known(1'b0, '0, 9'd16));
        directed.push_back(reg_row(CFG_PERIOD_LENGTH, 32'hFFFF_FC01));
        directed.push_back(reg_row(CFG_PHASE_STEP, 32'hFFFF_FFFF));
        directed.push_back(reg_row(CFG_AMP_FUNDAMENTAL, 32'd127));
        directed.push_back(reg_row(CFG_AMP_TENTH, 32'd127));
        directed.push_back(reg_row(CFG_AMP_FIFTH, 32'hFFFF_FF7F));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd255));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_known(1'b0, FULL_WORD, 9'd0));
        directed.push_back(reg_row(CFG_PERIOD_LENGTH, 32'd0));
        directed.push_back(req_known(1'b0, FULL_WORD, 9'd0));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd0));
        directed.push_back(req_known(1'b0, '0, 9'd0));
        directed.push_back(reg_row(CFG_PERIOD_LENGTH, 32'd20));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd128));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_row(1'b0));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd0));
        directed.push_back(reg_row(CFG_PHASE_STEP, 32'h4000_0000));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_row(1'b0));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd255));
        directed.push_back(req_row(1'b0));
        directed.push_back(reg_row(CFG_PERIOD_LENGTH, 32'd1023));
        directed.push_back(reg_row(CFG_PHASE_STEP, 32'd8388608));
        directed.push_back(reg_row(CFG_AMP_FUNDAMENTAL, 32'd50));
        directed.push_back(reg_row(CFG_AMP_TENTH, 32'd50));
        directed.push_back(reg_row(CFG_AMP_FIFTH, 32'd20));
        directed.push_back(reg_row(CFG_MID_OFFSET, 32'd128));
        directed.push_back(req_row(1'b0));
        directed.push_back(req_row(1'b1));
        directed.push_back(req_row(1'b0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle = $urandom_range(0, 1);
        rx_idle = $urandom_range(0, 1);

        // walk the table; always leave a gap before a register write so
        // valid is low while the block drains
        for (int r = 0; r < directed.size(); r++) begin
            if (directed[r].kind == ROW_REG_WRITE) begin
                drain_words();
                cfg_write(directed[r].addr, directed[r].data);
            end else begin
                gap = tx_gap();
                if (r + 1 == directed.size() || directed[r+1].kind == ROW_REG_WRITE) begin
                    gap = gap + 1;
                end
                push_request(directed[r].mute, gap, directed[r].known, directed[r].want);
            end
        end

        // random phases: drain, retune, then a run of requests; long runs
        // at a period of 512 or more reach the index range wrap
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain_words();
            tx_idle   = ($urandom_range(0, 2) != 0);
            rx_idle   = ($urandom_range(0, 2) != 0);
            mute_odds = 8;
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 2))
                        0:       plen = 10'd512;
                        1:       plen = 10'd1023;
                        default: plen = PLEN_W'($urandom_range(513, 1023));
                    endcase
                    run       = 150;
                    mute_odds = 32;
                end
                1: begin
                    plen = PLEN_W'($urandom_range(0, 3));
                    run  = $urandom_range(8, 30);
                end
                2: begin
                    plen = PLEN_W'($urandom_range(20, 512));
                    run  = $urandom_range(10, 80);
                end
                default: begin
                    plen = PLEN_W'($urandom_range(4, 64));
                    run  = $urandom_range(10, 60);
                end
            endcase
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = '1;
                2:       step = (plen == 0) ? STEP_W'($urandom) : STEP_W'((64'd1 << 32) / plen);
                default: step = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       ofs = '0;
                1:       ofs = '1;
                default: ofs = OFS_W'($urandom_range(0, 255));
            endcase

            cfg_write(CFG_PERIOD_LENGTH, with_stray_bits(CFG_DATA_W'(plen), PLEN_W));
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_PHASE_STEP, step);
            end
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_AMP_FUNDAMENTAL, with_stray_bits(CFG_DATA_W'(pick_amp()), AMP_W));
            end
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_AMP_TENTH, with_stray_bits(CFG_DATA_W'(pick_amp()), AMP_W));
            end
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_AMP_FIFTH, with_stray_bits(CFG_DATA_W'(pick_amp()), AMP_W));
            end
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_MID_OFFSET, with_stray_bits(CFG_DATA_W'(ofs), OFS_W));
            end
            if ($urandom_range(0, 3) == 0) begin
                cfg_write($urandom_range(0, 1) ? CFG_UNMAPPED_6 : CFG_UNMAPPED_7, $urandom);
            end

            for (int n = 0; n < run; n++) begin
                mute        = ($urandom_range(1, mute_odds) == 1);
                last_of_run = (n == run - 1);
                gap         = tx_gap() + (last_of_run ? 1 : 0);
                push_request(mute, gap, 1'b0, '0);
                random_sent++;
            end
        end

        // let the last words out, then give the block time to show strays
        drain_words();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
